### rtl/core/sdv_pkg.sv
`default_nettype none
package sdv_pkg;
  localparam int unsigned COORD_W = 24;  // input coordinate width
  localparam int unsigned SPD_W   = 16;  // speed width
  localparam int unsigned MAG_W   = 24;  // magnitude of a coordinate difference
  localparam int unsigned PROD_W  = MAG_W + SPD_W;  // |d| * |speed|
  localparam int unsigned SQ_W    = 2 * MAG_W + 1;  // dx^2 + dy^2
  localparam int unsigned LEN_W   = 25;  // integer square root of the sum
  localparam int unsigned RT_W    = SQ_W + 1;  // root working width
  localparam int unsigned Q_W     = 25;  // quotient bits kept by the divider
  localparam int unsigned OUT_W   = 24;

  localparam logic [Q_W-1:0] POS_LIMIT = Q_W'(24'h7FFFFF);
  localparam logic [Q_W-1:0] NEG_LIMIT = Q_W'(25'h0800000);
  localparam logic [OUT_W-1:0] OUT_MAX = 24'h7FFFFF;
  localparam logic [OUT_W-1:0] OUT_MIN = 24'h800000;
endpackage
`default_nettype wire

### rtl/core/sdv_front.sv
`default_nettype none
module sdv_front #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  wire                                     clk,
  input  wire                                     rst_n,
  input  wire                                     en,
  input  wire                                     v_in,
  input  wire signed [sdv_pkg::COORD_W-1:0]       start_x,
  input  wire signed [sdv_pkg::COORD_W-1:0]       start_y,
  input  wire signed [sdv_pkg::COORD_W-1:0]       end_x,
  input  wire signed [sdv_pkg::COORD_W-1:0]       end_y,
  input  wire signed [sdv_pkg::SPD_W-1:0]         speed,
  input  wire                                     speed_present,
  output logic                                    v_out,
  output logic [sdv_pkg::SQ_W-1:0]                sum_out,
  output logic [sdv_pkg::PROD_W+FRAC_BITS-1:0]    num_x_out,
  output logic [sdv_pkg::PROD_W+FRAC_BITS-1:0]    num_y_out,
  output logic                                    neg_x_out,
  output logic                                    neg_y_out
);
  import sdv_pkg::*;

  localparam int unsigned NUM_W = PROD_W + FRAC_BITS;

  logic signed [COORD_W:0] dx, dy;
  logic signed [SPD_W-1:0] spd;
  logic [MAG_W-1:0] ax_nxt, ay_nxt;
  logic [SPD_W-1:0] sm_nxt;

  logic             v1_r, v2_r, v3_r;
  logic [MAG_W-1:0] ax_r, ay_r;
  logic [SPD_W-1:0] sm_r;
  logic             nx1_r, ny1_r, nx2_r, ny2_r, nx3_r, ny3_r;
  logic [2*MAG_W-1:0] px_r, py_r;
  logic [PROD_W-1:0]  mx_r, my_r;
  logic [SQ_W-1:0]    sum_r;
  logic [NUM_W-1:0]   numx_r, numy_r;

  always_comb begin
    dx = {end_x[COORD_W-1], end_x} - {start_x[COORD_W-1], start_x};
    dy = {end_y[COORD_W-1], end_y} - {start_y[COORD_W-1], start_y};
    spd = speed_present ? speed : SPD_W'(1);
    ax_nxt = dx[COORD_W] ? MAG_W'(-dx) : MAG_W'(dx);
    ay_nxt = dy[COORD_W] ? MAG_W'(-dy) : MAG_W'(dy);
    sm_nxt = spd[SPD_W-1] ? SPD_W'(-spd) : SPD_W'(spd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= v_in;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax_r   <= ax_nxt;
      ay_r   <= ay_nxt;
      sm_r   <= sm_nxt;
      nx1_r  <= dx[COORD_W] != spd[SPD_W-1];
      ny1_r  <= dy[COORD_W] != spd[SPD_W-1];
      px_r   <= ax_r * ax_r;
      py_r   <= ay_r * ay_r;
      mx_r   <= ax_r * sm_r;
      my_r   <= ay_r * sm_r;
      nx2_r  <= nx1_r;
      ny2_r  <= ny1_r;
      sum_r  <= SQ_W'(px_r) + SQ_W'(py_r);
      numx_r <= NUM_W'(mx_r) << FRAC_BITS;
      numy_r <= NUM_W'(my_r) << FRAC_BITS;
      nx3_r  <= nx2_r;
      ny3_r  <= ny2_r;
    end
  end

  assign v_out     = v3_r;
  assign sum_out   = sum_r;
  assign num_x_out = numx_r;
  assign num_y_out = numy_r;
  assign neg_x_out = nx3_r;
  assign neg_y_out = ny3_r;
endmodule
`default_nettype wire

### rtl/core/sdv_sqrt.sv
`default_nettype none
module sdv_sqrt #(
  parameter int unsigned SIDE_W = 98
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           en,
  input  wire                           v_in,
  input  wire [sdv_pkg::SQ_W-1:0]       n_in,
  input  wire [SIDE_W-1:0]              side_in,
  output logic                          v_out,
  output logic [sdv_pkg::LEN_W-1:0]     len_out,
  output logic [SIDE_W-1:0]             side_out
);
  import sdv_pkg::*;

  // One root bit per stage, from the top pair of radicand bits down.
  localparam int unsigned NS = LEN_W;

  logic              vs [1:NS];
  logic [RT_W-1:0]   ns [1:NS];
  logic [RT_W-1:0]   rs [1:NS];
  logic [SIDE_W-1:0] ss [1:NS];

  for (genvar i = 0; i < NS; i++) begin : g_stage
    localparam logic [RT_W-1:0] BIT = RT_W'(1) << (2 * (NS - 1 - i));
    logic              v_i;
    logic [RT_W-1:0]   n_i;
    logic [RT_W-1:0]   r_i;
    logic [SIDE_W-1:0] s_i;
    logic [RT_W-1:0]   trial;
    logic              take;
    if (i == 0) begin : g_first
      assign v_i = v_in;
      assign n_i = RT_W'(n_in);
      assign r_i = '0;
      assign s_i = side_in;
    end else begin : g_next
      assign v_i = vs[i];
      assign n_i = ns[i];
      assign r_i = rs[i];
      assign s_i = ss[i];
    end
    always_comb begin
      trial = r_i + BIT;
      take  = n_i >= trial;
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vs[i+1] <= 1'b0;
      end else if (en) begin
        vs[i+1] <= v_i;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        ns[i+1] <= take ? n_i - trial : n_i;
        rs[i+1] <= take ? (r_i >> 1) + BIT : r_i >> 1;
        ss[i+1] <= s_i;
      end
    end
  end

  assign v_out    = vs[NS];
  assign len_out  = rs[NS][LEN_W-1:0];
  assign side_out = ss[NS];
endmodule
`default_nettype wire

### rtl/core/sdv_div.sv
`default_nettype none
module sdv_div #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   en,
  input  wire                                   v_in,
  input  wire [sdv_pkg::LEN_W-1:0]              len_in,
  input  wire [sdv_pkg::PROD_W+FRAC_BITS-1:0]   num_x_in,
  input  wire [sdv_pkg::PROD_W+FRAC_BITS-1:0]   num_y_in,
  input  wire                                   neg_x_in,
  input  wire                                   neg_y_in,
  output logic                                  v_out,
  output logic                                  zero_out,
  output logic [sdv_pkg::Q_W-1:0]               q_x_out,
  output logic [sdv_pkg::Q_W-1:0]               q_y_out,
  output logic                                  ovf_x_out,
  output logic                                  ovf_y_out,
  output logic                                  neg_x_out,
  output logic                                  neg_y_out
);
  import sdv_pkg::*;

  localparam int unsigned NUM_W = PROD_W + FRAC_BITS;
  localparam int unsigned NS    = Q_W;

  // Quotients of 2^Q_W or more only saturate, so the high part is
  // compared once and only Q_W quotient bits are developed.
  logic [NUM_W-1:0] hi_x, hi_y;
  assign hi_x = num_x_in >> Q_W;
  assign hi_y = num_y_in >> Q_W;

  logic             vs   [0:NS];
  logic [LEN_W-1:0] ls   [0:NS];
  logic [LEN_W-1:0] rx   [0:NS];
  logic [LEN_W-1:0] ry   [0:NS];
  logic [Q_W-1:0]   qx   [0:NS];
  logic [Q_W-1:0]   qy   [0:NS];
  logic [Q_W-1:0]   lx   [0:NS];
  logic [Q_W-1:0]   ly   [0:NS];
  logic             ox   [0:NS];
  logic             oy   [0:NS];
  logic             gx   [0:NS];
  logic             gy   [0:NS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vs[0] <= 1'b0;
    end else if (en) begin
      vs[0] <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ls[0] <= len_in;
      rx[0] <= hi_x[LEN_W-1:0];
      ry[0] <= hi_y[LEN_W-1:0];
      qx[0] <= '0;
      qy[0] <= '0;
      lx[0] <= num_x_in[Q_W-1:0];
      ly[0] <= num_y_in[Q_W-1:0];
      ox[0] <= hi_x >= NUM_W'(len_in);
      oy[0] <= hi_y >= NUM_W'(len_in);
      gx[0] <= neg_x_in;
      gy[0] <= neg_y_in;
    end
  end

  for (genvar j = 0; j < NS; j++) begin : g_stage
    logic [LEN_W:0] tx, ty;
    logic           kx, ky;
    always_comb begin
      tx = {rx[j], lx[j][NS-1-j]};
      ty = {ry[j], ly[j][NS-1-j]};
      kx = tx >= {1'b0, ls[j]};
      ky = ty >= {1'b0, ls[j]};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vs[j+1] <= 1'b0;
      end else if (en) begin
        vs[j+1] <= vs[j];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rx[j+1] <= kx ? LEN_W'(tx - {1'b0, ls[j]}) : tx[LEN_W-1:0];
        ry[j+1] <= ky ? LEN_W'(ty - {1'b0, ls[j]}) : ty[LEN_W-1:0];
        qx[j+1] <= {qx[j][Q_W-2:0], kx};
        qy[j+1] <= {qy[j][Q_W-2:0], ky};
        ls[j+1] <= ls[j];
        lx[j+1] <= lx[j];
        ly[j+1] <= ly[j];
        ox[j+1] <= ox[j];
        oy[j+1] <= oy[j];
        gx[j+1] <= gx[j];
        gy[j+1] <= gy[j];
      end
    end
  end

  assign v_out     = vs[NS];
  assign zero_out  = ls[NS] == '0;
  assign q_x_out   = qx[NS];
  assign q_y_out   = qy[NS];
  assign ovf_x_out = ox[NS];
  assign ovf_y_out = oy[NS];
  assign neg_x_out = gx[NS];
  assign neg_y_out = gy[NS];
endmodule
`default_nettype wire

### rtl/core/scaled_direction_vector.sv
`default_nettype none
// Channel  Beat fields (lowest bit first)                          Direction
// in_      tdata: start_x, start_y, end_x, end_y, speed             slave
//          tuser: speed_present
// out_     tdata: dir_x, dir_y; tuser: saturated                   master
//
// Each beat passes through 55 register stages: three for differences and
// products, 25 for the square root (one root bit per stage), 26 for the two
// lane divider (an input register, then one quotient bit per stage) and the output register.
// One beat is accepted every cycle while the output side takes results.
// Reset (rst_n low, synchronous) clears only the valid bits.
// A stall at out_tready freezes the whole pipeline, nothing is lost or repeated.
module scaled_direction_vector #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  // start_x[23:0], start_y[47:24], end_x[71:48], end_y[95:72], speed[111:96]
  input  wire  [111:0] in_tdata,
  // speed_present[0]
  input  wire  [0:0]   in_tuser,
  output logic         out_tvalid,
  input  wire          out_tready,
  // dir_x[23:0], dir_y[47:24]
  output logic [47:0]  out_tdata,
  // saturated[0]
  output logic [0:0]   out_tuser
);
  import sdv_pkg::*;

  localparam int unsigned NUM_W  = PROD_W + FRAC_BITS;
  localparam int unsigned SIDE_W = 2 * NUM_W + 2;

  // The pipeline moves as one: it advances whenever the output register
  // is empty or being drained.
  logic en;
  logic out_v_r;
  assign en        = !out_v_r || out_tready;
  assign in_tready = en;

  logic             f_v, f_nx, f_ny;
  logic [SQ_W-1:0]  f_sum;
  logic [NUM_W-1:0] f_numx, f_numy;

  sdv_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en),
    .v_in          (in_tvalid),
    .start_x       (in_tdata[23:0]),
    .start_y       (in_tdata[47:24]),
    .end_x         (in_tdata[71:48]),
    .end_y         (in_tdata[95:72]),
    .speed         (in_tdata[111:96]),
    .speed_present (in_tuser[0]),
    .v_out         (f_v),
    .sum_out       (f_sum),
    .num_x_out     (f_numx),
    .num_y_out     (f_numy),
    .neg_x_out     (f_nx),
    .neg_y_out     (f_ny)
  );

  // Numerators and signs ride along beside the root.
  logic              s_v;
  logic [LEN_W-1:0]  s_len;
  logic [SIDE_W-1:0] s_side;

  sdv_sqrt #(.SIDE_W(SIDE_W)) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .v_in     (f_v),
    .n_in     (f_sum),
    .side_in  ({f_ny, f_nx, f_numy, f_numx}),
    .v_out    (s_v),
    .len_out  (s_len),
    .side_out (s_side)
  );

  logic           d_v, d_zero, d_ox, d_oy, d_nx, d_ny;
  logic [Q_W-1:0] d_qx, d_qy;

  sdv_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .v_in      (s_v),
    .len_in    (s_len),
    .num_x_in  (s_side[NUM_W-1:0]),
    .num_y_in  (s_side[2*NUM_W-1:NUM_W]),
    .neg_x_in  (s_side[2*NUM_W]),
    .neg_y_in  (s_side[2*NUM_W+1]),
    .v_out     (d_v),
    .zero_out  (d_zero),
    .q_x_out   (d_qx),
    .q_y_out   (d_qy),
    .ovf_x_out (d_ox),
    .ovf_y_out (d_oy),
    .neg_x_out (d_nx),
    .neg_y_out (d_ny)
  );

  // Saturation and sign: a negative component may reach one step further
  // than a positive one. Coincident points give an all-zero result.
  logic [OUT_W-1:0] dir_x_nxt, dir_y_nxt;
  logic             sat_x, sat_y;
  logic [OUT_W-1:0] dir_x_r, dir_y_r;
  logic             sat_r;

  always_comb begin
    sat_x = d_ox || (d_nx ? d_qx > NEG_LIMIT : d_qx > POS_LIMIT);
    sat_y = d_oy || (d_ny ? d_qy > NEG_LIMIT : d_qy > POS_LIMIT);
    if (sat_x) begin
      dir_x_nxt = d_nx ? OUT_MIN : OUT_MAX;
    end else begin
      dir_x_nxt = d_nx ? OUT_W'(-d_qx) : d_qx[OUT_W-1:0];
    end
    if (sat_y) begin
      dir_y_nxt = d_ny ? OUT_MIN : OUT_MAX;
    end else begin
      dir_y_nxt = d_ny ? OUT_W'(-d_qy) : d_qy[OUT_W-1:0];
    end
    if (d_zero) begin
      dir_x_nxt = '0;
      dir_y_nxt = '0;
      sat_x     = 1'b0;
      sat_y     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= d_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dir_x_r <= dir_x_nxt;
      dir_y_r <= dir_y_nxt;
      sat_r   <= sat_x || sat_y;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {dir_y_r, dir_x_r};
  assign out_tuser  = sat_r;
endmodule
`default_nettype wire
